[hw/rtl/tawq_pkg.sv]
package tawq_pkg;

    // Fixed field widths of the request and result channels
    localparam int ACTION_W    = 1;
    localparam int REQ_ID_W    = 4;
    localparam int EVENT_W     = 3;
    localparam int RES_IDX_W   = 2;

    // Default sizing
    localparam int DEF_NUM_RESOURCES  = 4;
    localparam int DEF_NUM_REQUESTERS = 16;
    localparam int DEF_QUEUE_DEPTH    = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REQUEST = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [EVENT_W-1:0] {
        EV_GRANTED  = 3'd0,
        EV_QUEUED   = 3'd1,
        EV_RELEASED = 3'd2,
        EV_NOT_HELD = 3'd3,
        EV_DROPPED  = 3'd4
    } t_event;

endpackage

[hw/rtl/tawq_if.sv]
interface tawq_req_if
    import tawq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [REQ_ID_W-1:0] requester;

    modport source (output valid, output action, output requester, input ready);
    modport sink   (input valid, input action, input requester, output ready);
endinterface

interface tawq_res_if
    import tawq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [EVENT_W-1:0]   event_res;
    logic [REQ_ID_W-1:0]  who;
    logic [RES_IDX_W-1:0] resource;
    logic                 last;

    modport source (output valid, output event_res, output who, output resource,
                    output last, input ready);
    modport sink   (input valid, input event_res, input who, input resource,
                    input last, output ready);
endinterface

[hw/rtl/table_allocator_with_wait_queue_top.sv]
// A result is registered on the output from ST_EXEC, after the held-resource read;
// a release that hands the freed slot to a waiter gives its second result from ST_SERVE.
// A new request is taken only in ST_IDLE, so the block does not accept the next request
// before the last result of the previous one is registered. Output back-pressure stalls it.
// Reset (synchronous, active low): all resources free, nothing held, wait queue empty,
// search start at zero. The wait queue storage is not cleared and needs no clearing pass.
module table_allocator_with_wait_queue_top
    import tawq_pkg::*;
#(
    parameter int NUM_RESOURCES  = DEF_NUM_RESOURCES,
    parameter int NUM_REQUESTERS = DEF_NUM_REQUESTERS,
    parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tawq_req_if.sink   i_req,
    tawq_res_if.source o_res
);

    localparam int RW  = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int BW  = $clog2(NUM_RESOURCES + 1);
    localparam int IDW = $clog2(NUM_REQUESTERS);
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int MW  = ($clog2(NUM_REQUESTERS + 1) > REQ_ID_W) ?
                         $clog2(NUM_REQUESTERS + 1) : REQ_ID_W;
    localparam int MOD_STEPS = (1 << REQ_ID_W) / 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SERVE
    } t_state;

    // Memories
    logic [RW-1:0]  m_held [NUM_REQUESTERS];
    logic [IDW-1:0] m_wait [QUEUE_DEPTH];

    // Registers
    t_state                    r_state,      n_state;
    logic [NUM_RESOURCES-1:0]  r_busy_map,   n_busy_map;
    logic [BW-1:0]             r_busy_count, n_busy_count;
    logic [RW-1:0]             r_start,      n_start;
    logic [NUM_REQUESTERS-1:0] r_held_vld,   n_held_vld;
    logic [QW-1:0]             r_head,       n_head;
    logic [QW-1:0]             r_tail,       n_tail;
    logic [CW-1:0]             r_wait_count, n_wait_count;
    t_action                   r_act,        n_act;
    logic [IDW-1:0]            r_id,         n_id;
    logic [IDW-1:0]            r_next,       n_next;
    logic                      r_out_valid,  n_out_valid;
    t_event                    r_out_event,  n_out_event;
    logic [IDW-1:0]            r_out_who,    n_out_who;
    logic [RW-1:0]             r_out_res,    n_out_res;
    logic                      r_out_last,   n_out_last;
    logic [RW-1:0]             r_held_rd;
    logic [IDW-1:0]            r_wait_rd;

    // Memory ports
    logic           held_rd_en;
    logic [IDW-1:0] held_rd_addr;
    logic           held_wr_en;
    logic [IDW-1:0] held_wr_addr;
    logic [RW-1:0]  held_wr_data;
    logic           wait_rd_en;
    logic           wait_wr_en;
    logic [IDW-1:0] wait_wr_data;

    logic           accept;
    logic           out_free;
    logic           serve_go;
    logic [IDW-1:0] s_id;
    logic [IDW-1:0] red_id;
    logic [MW-1:0]  mod_val;
    logic           hi_hit;
    logic [RW-1:0]  hi_idx;
    logic [RW-1:0]  lo_idx;
    logic [RW-1:0]  pick;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    assign o_res.valid     = r_out_valid;
    assign o_res.event_res = r_out_event;
    assign o_res.who       = REQ_ID_W'(r_out_who);
    assign o_res.resource  = RES_IDX_W'(r_out_res);
    assign o_res.last      = r_out_last;

    // Fold an out-of-range id back into the requester range
    always_comb begin
        mod_val = MW'(i_req.requester);
        for (int k = 0; k < MOD_STEPS; k++) begin
            if (mod_val >= MW'(NUM_REQUESTERS)) begin
                mod_val = mod_val - MW'(NUM_REQUESTERS);
            end
        end
        red_id = IDW'(mod_val);
    end

    // Rotating search: lowest free slot at or after the start, else lowest free slot
    always_comb begin
        hi_hit = 1'b0;
        hi_idx = '0;
        lo_idx = '0;
        for (int k = NUM_RESOURCES - 1; k >= 0; k--) begin
            if (!r_busy_map[k]) begin
                lo_idx = RW'(k);
                if (RW'(k) >= r_start) begin
                    hi_hit = 1'b1;
                    hi_idx = RW'(k);
                end
            end
        end
        pick = hi_hit ? hi_idx : lo_idx;
    end

    assign serve_go = out_free &&
                      (((r_state == ST_EXEC) && (r_act == ACT_REQUEST)) ||
                       (r_state == ST_SERVE));
    assign s_id     = (r_state == ST_SERVE) ? r_next : r_id;

    always_comb begin
        n_state      = r_state;
        n_busy_map   = r_busy_map;
        n_busy_count = r_busy_count;
        n_start      = r_start;
        n_held_vld   = r_held_vld;
        n_head       = r_head;
        n_tail       = r_tail;
        n_wait_count = r_wait_count;
        n_act        = r_act;
        n_id         = r_id;
        n_next       = r_next;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_event  = r_out_event;
        n_out_who    = r_out_who;
        n_out_res    = r_out_res;
        n_out_last   = r_out_last;
        held_rd_en   = 1'b0;
        held_rd_addr = red_id;
        held_wr_en   = 1'b0;
        held_wr_addr = s_id;
        held_wr_data = pick;
        wait_rd_en   = 1'b0;
        wait_wr_en   = 1'b0;
        wait_wr_data = s_id;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_act      = t_action'(i_req.action);
                    n_id       = red_id;
                    held_rd_en = 1'b1;
                    wait_rd_en = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free && (r_act == ACT_RELEASE)) begin
                    n_out_valid = 1'b1;
                    n_out_who   = r_id;
                    if (!r_held_vld[r_id]) begin
                        n_out_event = EV_NOT_HELD;
                        n_out_res   = '0;
                        n_out_last  = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_held_vld[r_id] = 1'b0;
                        if (r_busy_map[r_held_rd]) begin
                            n_busy_map[r_held_rd] = 1'b0;
                            n_busy_count          = r_busy_count - BW'(1);
                        end
                        n_out_event = EV_RELEASED;
                        n_out_res   = r_held_rd;
                        if (r_wait_count == '0) begin
                            n_out_last = 1'b1;
                            n_state    = ST_IDLE;
                        end else begin
                            // pop the head and look up what it holds
                            n_out_last   = 1'b0;
                            n_next       = r_wait_rd;
                            n_head       = (r_head == QW'(QUEUE_DEPTH - 1)) ?
                                           '0 : r_head + QW'(1);
                            n_wait_count = r_wait_count - CW'(1);
                            held_rd_en   = 1'b1;
                            held_rd_addr = r_wait_rd;
                            n_state      = ST_SERVE;
                        end
                    end
                end
            end
            ST_SERVE: begin
                // handled by the serve path below
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (serve_go) begin
            n_out_valid = 1'b1;
            n_out_who   = s_id;
            n_out_last  = 1'b1;
            n_state     = ST_IDLE;
            if (r_held_vld[s_id]) begin
                n_out_event = EV_GRANTED;
                n_out_res   = r_held_rd;
            end else if (r_busy_count < BW'(NUM_RESOURCES)) begin
                n_busy_map[pick] = 1'b1;
                n_busy_count     = r_busy_count + BW'(1);
                n_start          = (pick == RW'(NUM_RESOURCES - 1)) ? '0 : pick + RW'(1);
                n_held_vld[s_id] = 1'b1;
                held_wr_en       = 1'b1;
                n_out_event      = EV_GRANTED;
                n_out_res        = pick;
            end else if (r_wait_count >= CW'(QUEUE_DEPTH)) begin
                n_out_event = EV_DROPPED;
                n_out_res   = '0;
            end else begin
                wait_wr_en   = 1'b1;
                n_tail       = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + QW'(1);
                n_wait_count = r_wait_count + CW'(1);
                n_out_event  = EV_QUEUED;
                n_out_res    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_busy_map   <= '0;
            r_busy_count <= '0;
            r_start      <= '0;
            r_held_vld   <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_wait_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_busy_map   <= n_busy_map;
            r_busy_count <= n_busy_count;
            r_start      <= n_start;
            r_held_vld   <= n_held_vld;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_wait_count <= n_wait_count;
            r_out_valid  <= n_out_valid;
            r_act        <= n_act;
            r_id         <= n_id;
            r_next       <= n_next;
            r_out_event  <= n_out_event;
            r_out_who    <= n_out_who;
            r_out_res    <= n_out_res;
            r_out_last   <= n_out_last;
        end
    end

    // Held-resource table
    always_ff @(posedge i_clk) begin
        if (held_wr_en) begin
            m_held[held_wr_addr] <= held_wr_data;
        end
        if (held_rd_en) begin
            r_held_rd <= m_held[held_rd_addr];
        end
    end

    // Wait queue storage
    always_ff @(posedge i_clk) begin
        if (wait_wr_en) begin
            m_wait[r_tail] <= wait_wr_data;
        end
        if (wait_rd_en) begin
            r_wait_rd <= m_wait[r_head];
        end
    end

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy_count == BW'($countones(r_busy_map)))
        else $error("busy count disagrees with busy map");

    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait_count <= CW'(QUEUE_DEPTH))
        else $error("wait count above queue depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted request did not start execution");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_event == EV_RELEASED))
        else $error("non-final result is not a release");

    a_serve_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_SERVE) |-> ($past(r_state) == ST_EXEC) &&
                                       ($past(r_act) == ACT_RELEASE))
        else $error("waiter served outside a release");

endmodule

[sim/tb_table_allocator_with_wait_queue_top.sv]
module tb_table_allocator_with_wait_queue_top;
    import tawq_pkg::*;

    localparam int NRES     = DEF_NUM_RESOURCES;
    localparam int NREQ     = DEF_NUM_REQUESTERS;
    localparam int QDEPTH   = DEF_QUEUE_DEPTH;
    localparam int N_RANDOM = 500;
    localparam int N_PLAN   = 25;
    localparam int LIMIT    = 400000;

    typedef logic [REQ_ID_W-1:0]  t_id;
    typedef logic [RES_IDX_W-1:0] t_slot;

    typedef struct packed {
        t_event ev;
        t_id    who;
        t_slot  res;
        logic   last;
    } t_outcome;

    typedef struct packed {
        t_action act;
        t_id     id;
        logic    typed;
        t_event  ev;
        t_slot   res;
    } t_plan_row;

    logic i_clk;
    logic i_rst_n;

    tawq_req_if req_if();
    tawq_res_if res_if();

    table_allocator_with_wait_queue_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Mirror of the allocator state
    logic [NRES-1:0] busy_bits;
    int              busy_cnt;
    int              search_from;
    bit              holds    [NREQ];
    t_slot           held_at  [NREQ];
    t_id             waiters  [$];

    t_outcome pending_events [$];
    int       fails;
    bit       src_calm;
    bit       snk_calm;
    int       cyc;

    // A release with nothing held, all resources busy with four holders (0, 15, 9, 6), then sixteen waiters
    // with repeats, one dropped request, and two releases that serve waiters.
    t_plan_row plan [N_PLAN] = '{
        '{ACT_RELEASE, 4'd0,  1'b1, EV_NOT_HELD, 2'd0},
        '{ACT_REQUEST, 4'd0,  1'b1, EV_GRANTED,  2'd0},
        '{ACT_REQUEST, 4'd15, 1'b1, EV_GRANTED,  2'd1},
        '{ACT_REQUEST, 4'd0,  1'b1, EV_GRANTED,  2'd0},
        '{ACT_REQUEST, 4'd9,  1'b1, EV_GRANTED,  2'd2},
        '{ACT_REQUEST, 4'd6,  1'b1, EV_GRANTED,  2'd3},
        '{ACT_REQUEST, 4'd1,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd1,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd2,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd3,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd4,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd5,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd7,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd8,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd10, 1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd11, 1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd12, 1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd13, 1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd14, 1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd2,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd3,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd4,  1'b1, EV_QUEUED,   2'd0},
        '{ACT_REQUEST, 4'd5,  1'b1, EV_DROPPED,  2'd0},
        '{ACT_RELEASE, 4'd15, 1'b0, EV_GRANTED,  2'd0},
        '{ACT_RELEASE, 4'd1,  1'b0, EV_GRANTED,  2'd0}
    };

    function void post_event(t_event ev, t_id who, t_slot res, logic last);
        pending_events.push_back(t_outcome'{ev, who, res, last});
    endfunction

    function void serve_allocation(t_id who);
        int k;
        int t;
        if (holds[who]) begin
            post_event(EV_GRANTED, who, held_at[who], 1'b1);
            return;
        end
        if (busy_cnt < NRES) begin
            for (k = 0; k < NRES; k++) begin
                t = (search_from + k) % NRES;
                if (!busy_bits[t]) begin
                    busy_bits[t] = 1'b1;
                    busy_cnt++;
                    search_from  = (t + 1) % NRES;
                    holds[who]   = 1'b1;
                    held_at[who] = t_slot'(t);
                    post_event(EV_GRANTED, who, t_slot'(t), 1'b1);
                    return;
                end
            end
        end
        if (waiters.size() >= QDEPTH) begin
            post_event(EV_DROPPED, who, '0, 1'b1);
        end else begin
            waiters.push_back(who);
            post_event(EV_QUEUED, who, '0, 1'b1);
        end
    endfunction

    function void predict_allocation(t_action act, t_id who);
        t_slot t;
        if (act == ACT_REQUEST) begin
            serve_allocation(who);
        end else if (!holds[who]) begin
            post_event(EV_NOT_HELD, who, '0, 1'b1);
        end else begin
            t = held_at[who];
            holds[who]   = 1'b0;
            held_at[who] = '0;
            if (busy_bits[t]) begin
                busy_bits[t] = 1'b0;
                busy_cnt--;
            end
            if (waiters.size() == 0) begin
                post_event(EV_RELEASED, who, t, 1'b1);
            end else begin
                post_event(EV_RELEASED, who, t, 1'b0);
                serve_allocation(waiters.pop_front());
            end
        end
    endfunction

    function void check_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    // Present one request, hold it until taken, then idle for a random gap (possibly none) before the next one
    task automatic issue_request(t_action act, t_id who, logic typed, t_event ev, t_slot res);
        int g;
        req_if.valid     <= 1'b1;
        req_if.action    <= act;
        req_if.requester <= who;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        predict_allocation(act, who);
        if (typed)
            pending_events[pending_events.size() - 1] = t_outcome'{ev, who, res, 1'b1};
        g = src_calm ? 0 : $urandom_range(0, 11);
        if (g > 0) begin
            req_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cyc = 0;
        while (cyc < LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stalls, compare each result with the oldest expectation
    initial begin
        int       g;
        int       taken;
        t_outcome want;
        res_if.ready = 1'b0;
        taken    = 0;
        snk_calm = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            g = snk_calm ? 0 : $urandom_range(0, 11);
            if (g > 0) begin
                res_if.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result ev=%0d who=%0d res=%0d last=%0d", $time,
                         res_if.event_res, res_if.who, res_if.resource, res_if.last);
                fails++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_res", 4'(want.ev), 4'(res_if.event_res));
                check_field("who", 4'(want.who), 4'(res_if.who));
                check_field("resource", 4'(want.res), 4'(res_if.resource));
                check_field("last", 4'(want.last), 4'(res_if.last));
            end
            taken++;
            if (taken % 40 == 0)
                snk_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int      n;
        int      req_pct;
        t_action act;
        t_id     who;
        t_id     holders [$];

        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.action    = ACT_REQUEST;
        req_if.requester = '0;
        fails       = 0;
        src_calm    = 1'b0;
        busy_bits   = '0;
        busy_cnt    = 0;
        search_from = 0;
        for (n = 0; n < NREQ; n++) begin
            holds[n]   = 1'b0;
            held_at[n] = '0;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < N_PLAN; n++)
            issue_request(plan[n].act, plan[n].id, plan[n].typed, plan[n].ev, plan[n].res);

        req_pct = 55;
        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: req_pct = 30;
                    1: req_pct = 55;
                    default: req_pct = 80;
                endcase
                src_calm = ($urandom_range(0, 3) == 0);
            end
            who = t_id'($urandom_range(0, NREQ - 1));
            if ($urandom_range(1, 100) <= req_pct) begin
                act = ACT_REQUEST;
            end else begin
                act = ACT_RELEASE;
                // mostly release from a current holder, sometimes from anyone
                holders.delete();
                foreach (holds[i])
                    if (holds[i]) holders.push_back(t_id'(i));
                if (holders.size() != 0 && $urandom_range(0, 3) != 0)
                    who = holders[$urandom_range(0, holders.size() - 1)];
            end
            issue_request(act, who, 1'b0, EV_GRANTED, '0);
        end
        req_if.valid <= 1'b0;

        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tawq_pkg.sv
hw/rtl/tawq_if.sv
hw/rtl/table_allocator_with_wait_queue_top.sv
sim/tb_table_allocator_with_wait_queue_top.sv
